// File: design/acpu_pkg.sv
// acpu_pkg: shared constants and types for the accumulator processor core
// used by acpu_mem and accumulator_cpu_with_interrupts_core; no dependencies
package acpu_pkg;

  // word store geometry (power of two so address wrap is a bit-select)
  localparam int unsigned MemDepth = 2048;
  localparam int unsigned AddrW    = $clog2(MemDepth);

  // fixed addresses
  localparam logic [AddrW-1:0] UserLimit    = AddrW'(1000);
  localparam logic [AddrW-1:0] TimerEntry   = AddrW'(1000);
  localparam logic [AddrW-1:0] SyscallEntry = AddrW'(1500);
  localparam logic [AddrW-1:0] StackHi      = AddrW'(1999);
  localparam logic [AddrW-1:0] StackLo      = AddrW'(1998);

  // random source
  localparam logic [15:0] LfsrTaps  = 16'hB400;
  localparam logic [15:0] LfsrSeed  = 16'h0001;
  localparam logic [16:0] RndRecip  = 17'd83887;  // ceil(2^23 / 100)
  localparam int unsigned RndShift  = 23;
  localparam logic [31:0] RndRange  = 32'd100;

  // result fault codes
  typedef enum logic [1:0] {
    FaultNone   = 2'd0,
    FaultMem    = 2'd1,
    FaultOpcode = 2'd2
  } fault_e;

  // active interrupt codes
  typedef enum logic [1:0] {
    IrqNone    = 2'd0,
    IrqTimer   = 2'd1,
    IrqSyscall = 2'd2
  } irq_e;

  // memory port request
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [31:0]      wdata;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

endpackage

// File: design/acpu_mem.sv
// acpu_mem: word store, one write and one registered read per cycle
// depends on acpu_pkg for the address width and request struct
module acpu_mem (
  input  logic              clk_i,
  input  acpu_pkg::mem_req_t req_i,
  output logic [31:0]       rdata_o
);

  logic [31:0] mem [acpu_pkg::MemDepth];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_o <= mem[req_i.raddr];
  end

endmodule

// File: design/accumulator_cpu_with_interrupts_core.sv
// accumulator_cpu_with_interrupts_core: top level of the accumulator processor
// depends on acpu_pkg and acpu_mem
//
// Usage
//   Input channel (in_valid_i/in_ready_o) carries one beat per item: kind_i 0
//   writes load_value_i to word load_address_i, kind_i 1 runs one instruction
//   (taking a pending timer interrupt first). Every input beat yields exactly
//   one output beat (out_valid_o/out_ready_i) with print, halted and fault.
//   The timer interval is to be written through cfg_we_i/cfg_data_i
//   while idle; the user must ensure this, as the core does not enforce it.
//   A load writes its word and goes straight to the result transfer. A step
//   passes through a state for each access to the single word store (fetch,
//   operand, up to two data reads, interrupt entry pushes of two words) plus
//   decode, commit and the result transfer. One item is in work at a time; a
//   new beat is taken once the previous result sits in the output register.
// Reset
//   After rst_ni the word store is cleared one word per cycle, with
//   in_ready_o low; configuration writes are taken meanwhile.
// Stall
//   A result waits in the output register while out_ready_i is low; the core
//   then holds its next result until the register is free.
module accumulator_cpu_with_interrupts_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [10:0] load_address_i,
  input  logic signed [31:0] load_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        print_valid_o,
  output logic        print_as_char_o,
  output logic signed [31:0] print_value_o,
  output logic        halted_o,
  output logic [1:0]  fault_o
);

  localparam int unsigned AW = acpu_pkg::AddrW;

  typedef enum logic [5:0] {
    OpLoadValue  = 6'd1,  OpLoadAddr  = 6'd2,  OpLoadInd   = 6'd3,
    OpLoadIdxX   = 6'd4,  OpLoadIdxY  = 6'd5,  OpLoadSpX   = 6'd6,
    OpStore      = 6'd7,  OpGet       = 6'd8,  OpPut       = 6'd9,
    OpAddX       = 6'd10, OpAddY      = 6'd11, OpSubX      = 6'd12,
    OpSubY       = 6'd13, OpCopyToX   = 6'd14, OpCopyFromX = 6'd15,
    OpCopyToY    = 6'd16, OpCopyFromY = 6'd17, OpCopyToSp  = 6'd18,
    OpCopyFromSp = 6'd19, OpJump      = 6'd20, OpJumpEq    = 6'd21,
    OpJumpNe     = 6'd22, OpCall      = 6'd23, OpRet       = 6'd24,
    OpIncX       = 6'd25, OpDecX      = 6'd26, OpPush      = 6'd27,
    OpPop        = 6'd28, OpSyscall   = 6'd29, OpIret      = 6'd30,
    OpEnd        = 6'd50
  } op_e;

  typedef enum logic [3:0] {
    SClear, SIdle, SPushHi, SPushLo, SFetch, SOp, SOpnd, SExec,
    SInd, SData, SRnd, SPopPc, SRetSp, SRetPc, SCommit, SResp
  } state_e;

  state_e              state_q, state_d;
  logic [AW-1:0]       clr_q, clr_d;
  logic [AW-1:0]       pc_q, pc_d, sp_q, sp_d, npc_q, npc_d, ssp_q, ssp_d;
  logic [31:0]         ac_q, ac_d, x_q, x_d, y_q, y_d, opnd_q, opnd_d;
  logic                kern_q, kern_d, pend_q, pend_d, stop_q, stop_d;
  logic                sys_q, sys_d;
  acpu_pkg::irq_e      act_q, act_d;
  logic [15:0]         tick_q, tick_d, lfsr_q, lfsr_d, tint_q, tint_d;
  op_e                 op_q, op_d;
  logic [9:0]          rq_q, rq_d;
  logic                rpv_q, rpv_d, rpc_q, rpc_d, rhalt_q, rhalt_d;
  logic [31:0]         rval_q, rval_d;
  acpu_pkg::fault_e    rfault_q, rfault_d;
  logic                ov_q, ov_d, opv_q, opv_d, opc_q, opc_d, ohalt_q, ohalt_d;
  logic [31:0]         oval_q, oval_d;
  acpu_pkg::fault_e    ofault_q, ofault_d;

  acpu_pkg::mem_req_t  mreq;
  logic [31:0]         rdata;

  // scratch for the step logic
  logic [AW-1:0]       a_w, b_w;
  logic                two_w;
  op_e                 dec_w;
  logic [15:0]         lnext_w, tnext_w;
  logic [32:0]         rprod_w;

  acpu_mem u_mem (
    .clk_i  (clk_i),
    .req_i  (mreq),
    .rdata_o(rdata)
  );

  function automatic logic may(input logic kern, input logic [AW-1:0] a);
    may = kern || (a < acpu_pkg::UserLimit);
  endfunction

  // next-state logic of the sequencer
  always_comb begin
    state_d = state_q;  clr_d = clr_q;   pc_d = pc_q;     sp_d = sp_q;
    npc_d = npc_q;      ssp_d = ssp_q;   ac_d = ac_q;     x_d = x_q;
    y_d = y_q;          opnd_d = opnd_q; kern_d = kern_q; pend_d = pend_q;
    stop_d = stop_q;    sys_d = sys_q;   act_d = act_q;   tick_d = tick_q;
    lfsr_d = lfsr_q;    op_d = op_q;     rq_d = rq_q;     rpv_d = rpv_q;
    rpc_d = rpc_q;      rhalt_d = rhalt_q; rval_d = rval_q; rfault_d = rfault_q;
    ov_d = ov_q && !out_ready_i;
    opv_d = opv_q;      opc_d = opc_q;   ohalt_d = ohalt_q; oval_d = oval_q;
    ofault_d = ofault_q;
    tint_d = cfg_we_i ? cfg_data_i : tint_q;
    mreq = '{we: 1'b0, waddr: '0, wdata: '0, raddr: pc_q};
    a_w = '0;  b_w = '0;  two_w = 1'b0;  tnext_w = tick_q + 16'd1;
    dec_w = op_e'((rdata[31:6] == '0) ? rdata[5:0] : 6'd0);
    lnext_w = lfsr_q[0] ? ((lfsr_q >> 1) ^ acpu_pkg::LfsrTaps) : (lfsr_q >> 1);
    rprod_w = {17'b0, lnext_w} * {16'b0, acpu_pkg::RndRecip};

    unique case (state_q)
      // clearing sweep after reset
      SClear: begin
        mreq.we = 1'b1;
        mreq.waddr = clr_q;
        clr_d = clr_q + AW'(1);
        if (clr_q == '1) state_d = SIdle;
      end
      // take one input beat
      SIdle: begin
        if (in_valid_i) begin
          rpv_d = 1'b0;  rpc_d = 1'b0;  rval_d = '0;
          rhalt_d = stop_q;  rfault_d = acpu_pkg::FaultNone;
          if (!kind_i) begin
            mreq.we = 1'b1;
            mreq.waddr = load_address_i[AW-1:0];
            mreq.wdata = load_value_i;
            state_d = SResp;
          end else if (stop_q) begin
            state_d = SResp;
          end else if (pend_q && act_q == acpu_pkg::IrqNone) begin
            pend_d = 1'b0;  sys_d = 1'b0;  npc_d = pc_q;
            state_d = SPushHi;
          end else begin
            state_d = SFetch;
          end
        end
      end
      // interrupt entry: resume pc, then old sp
      SPushHi: begin
        mreq.we = 1'b1;
        mreq.waddr = acpu_pkg::StackHi;
        mreq.wdata = {{(32-AW){1'b0}}, npc_q};
        state_d = SPushLo;
      end
      SPushLo: begin
        mreq.we = 1'b1;
        mreq.waddr = acpu_pkg::StackLo;
        mreq.wdata = {{(32-AW){1'b0}}, sp_q};
        sp_d = acpu_pkg::StackLo;
        kern_d = 1'b1;
        if (sys_q) begin
          act_d = acpu_pkg::IrqSyscall;
          npc_d = acpu_pkg::SyscallEntry;
          state_d = SCommit;
        end else begin
          act_d = acpu_pkg::IrqTimer;
          pc_d = acpu_pkg::TimerEntry;
          state_d = SFetch;
        end
      end
      // instruction fetch
      SFetch: begin
        if (!may(kern_q, pc_q)) begin
          stop_d = 1'b1;  rhalt_d = 1'b1;  rfault_d = acpu_pkg::FaultMem;
          state_d = SResp;
        end else begin
          mreq.raddr = pc_q;
          state_d = SOp;
        end
      end
      // decode and operand read
      SOp: begin
        op_d = dec_w;
        two_w = (dec_w == OpLoadValue) || (dec_w == OpLoadAddr) ||
                (dec_w == OpLoadInd) || (dec_w == OpLoadIdxX) ||
                (dec_w == OpLoadIdxY) || (dec_w == OpStore) ||
                (dec_w == OpPut) || (dec_w == OpJump) || (dec_w == OpJumpEq) ||
                (dec_w == OpJumpNe) || (dec_w == OpCall);
        npc_d = pc_q + (two_w ? AW'(2) : AW'(1));
        opnd_d = '0;
        a_w = pc_q + AW'(1);
        if (!two_w) begin
          state_d = SExec;
        end else if (!may(kern_q, a_w)) begin
          stop_d = 1'b1;  rhalt_d = 1'b1;  rfault_d = acpu_pkg::FaultMem;
          state_d = SResp;
        end else begin
          mreq.raddr = a_w;
          state_d = SOpnd;
        end
      end
      SOpnd: begin
        opnd_d = rdata;
        state_d = SExec;
      end
      // execute
      SExec: begin
        state_d = SCommit;
        unique case (op_q)
          OpLoadAddr, OpLoadInd, OpLoadIdxX, OpLoadIdxY, OpLoadSpX, OpRet,
          OpPop: begin
            priority case (op_q)
              OpLoadIdxX: a_w = opnd_q[AW-1:0] + x_q[AW-1:0];
              OpLoadIdxY: a_w = opnd_q[AW-1:0] + y_q[AW-1:0];
              OpLoadSpX:  a_w = sp_q + x_q[AW-1:0];
              OpRet, OpPop: a_w = sp_q;
              default:    a_w = opnd_q[AW-1:0];
            endcase
            mreq.raddr = a_w;
            if (op_q == OpLoadInd) state_d = SInd;
            else if (op_q == OpRet) state_d = SPopPc;
            else state_d = SData;
            if (op_q == OpRet || op_q == OpPop) sp_d = sp_q + AW'(1);
            if (!may(kern_q, a_w)) begin
              sp_d = sp_q;
              stop_d = 1'b1;  rhalt_d = 1'b1;  rfault_d = acpu_pkg::FaultMem;
              state_d = SResp;
            end
          end
          OpLoadValue:  ac_d = opnd_q;
          OpStore, OpCall, OpPush: begin
            a_w = (op_q == OpStore) ? opnd_q[AW-1:0] : sp_q - AW'(1);
            if (!may(kern_q, a_w)) begin
              stop_d = 1'b1;  rhalt_d = 1'b1;  rfault_d = acpu_pkg::FaultMem;
              state_d = SResp;
            end else begin
              mreq.we = 1'b1;
              mreq.waddr = a_w;
              mreq.wdata = (op_q == OpCall) ? {{(32-AW){1'b0}}, npc_q} : ac_q;
              if (op_q != OpStore) sp_d = a_w;
              if (op_q == OpCall) npc_d = opnd_q[AW-1:0];
            end
          end
          OpGet: begin
            lfsr_d = lnext_w;
            rq_d = rprod_w[acpu_pkg::RndShift +: 10];
            state_d = SRnd;
          end
          OpPut: begin
            if (opnd_q == 32'd1 || opnd_q == 32'd2) begin
              rpv_d = 1'b1;
              rpc_d = (opnd_q == 32'd2);
              rval_d = ac_q;
            end
          end
          OpAddX:       ac_d = ac_q + x_q;
          OpAddY:       ac_d = ac_q + y_q;
          OpSubX:       ac_d = ac_q - x_q;
          OpSubY:       ac_d = ac_q - y_q;
          OpCopyToX:    x_d = ac_q;
          OpCopyFromX:  ac_d = x_q;
          OpCopyToY:    y_d = ac_q;
          OpCopyFromY:  ac_d = y_q;
          OpCopyToSp:   sp_d = ac_q[AW-1:0];
          OpCopyFromSp: ac_d = {{(32-AW){1'b0}}, sp_q};
          OpJump:       npc_d = opnd_q[AW-1:0];
          OpJumpEq:     if (ac_q == '0) npc_d = opnd_q[AW-1:0];
          OpJumpNe:     if (ac_q != '0) npc_d = opnd_q[AW-1:0];
          OpIncX:       x_d = x_q + 32'd1;
          OpDecX:       x_d = x_q - 32'd1;
          OpSyscall: begin
            if (act_q == acpu_pkg::IrqNone) begin
              sys_d = 1'b1;
              state_d = SPushHi;
            end
          end
          OpIret: begin
            b_w = sp_q + AW'(1);
            if (!may(kern_q, sp_q) || !may(kern_q, b_w)) begin
              stop_d = 1'b1;  rhalt_d = 1'b1;  rfault_d = acpu_pkg::FaultMem;
              state_d = SResp;
            end else begin
              mreq.raddr = sp_q;
              state_d = SRetSp;
            end
          end
          OpEnd: begin
            stop_d = 1'b1;  rhalt_d = 1'b1;
            state_d = SResp;
          end
          default:      rfault_d = acpu_pkg::FaultOpcode;
        endcase
      end
      // second level of an indirect load
      SInd: begin
        a_w = rdata[AW-1:0];
        if (!may(kern_q, a_w)) begin
          stop_d = 1'b1;  rhalt_d = 1'b1;  rfault_d = acpu_pkg::FaultMem;
          state_d = SResp;
        end else begin
          mreq.raddr = a_w;
          state_d = SData;
        end
      end
      SData: begin
        ac_d = rdata;
        state_d = SCommit;
      end
      // remainder by 100, plus one, from the registered quotient
      SRnd: begin
        ac_d = {16'b0, lfsr_q} - {22'b0, rq_q} * acpu_pkg::RndRange + 32'd1;
        state_d = SCommit;
      end
      SPopPc: begin
        npc_d = rdata[AW-1:0];
        state_d = SCommit;
      end
      // interrupt return: saved sp, then pc
      SRetSp: begin
        ssp_d = rdata[AW-1:0];
        mreq.raddr = sp_q + AW'(1);
        state_d = SRetPc;
      end
      SRetPc: begin
        npc_d = rdata[AW-1:0];
        if (act_q == acpu_pkg::IrqTimer) pend_d = 1'b0;
        act_d = acpu_pkg::IrqNone;
        kern_d = 1'b0;
        sp_d = ssp_q;
        state_d = SCommit;
      end
      // retire: pc and timer tick
      SCommit: begin
        pc_d = npc_q;
        tick_d = tnext_w;
        if (tint_q != '0 && tnext_w >= tint_q) begin
          pend_d = 1'b1;
          tick_d = '0;
        end
        state_d = SResp;
      end
      // hand the result to the output register
      SResp: begin
        if (!ov_q || out_ready_i) begin
          ov_d = 1'b1;  opv_d = rpv_q;  opc_d = rpc_q;  oval_d = rval_q;
          ohalt_d = rhalt_q;  ofault_d = rfault_q;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;  clr_q <= '0;  pc_q <= '0;  sp_q <= acpu_pkg::UserLimit;
      ac_q <= '0;  x_q <= '0;  y_q <= '0;  kern_q <= 1'b0;  pend_q <= 1'b0;
      stop_q <= 1'b0;  act_q <= acpu_pkg::IrqNone;  tick_q <= '0;
      lfsr_q <= acpu_pkg::LfsrSeed;  tint_q <= '0;  ov_q <= 1'b0;
    end else begin
      state_q <= state_d;  clr_q <= clr_d;  pc_q <= pc_d;  sp_q <= sp_d;
      ac_q <= ac_d;  x_q <= x_d;  y_q <= y_d;  kern_q <= kern_d;  pend_q <= pend_d;
      stop_q <= stop_d;  act_q <= act_d;  tick_q <= tick_d;
      lfsr_q <= lfsr_d;  tint_q <= tint_d;  ov_q <= ov_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    npc_q <= npc_d;  ssp_q <= ssp_d;  opnd_q <= opnd_d;  sys_q <= sys_d;
    op_q <= op_d;  rq_q <= rq_d;  rpv_q <= rpv_d;  rpc_q <= rpc_d;
    rhalt_q <= rhalt_d;  rval_q <= rval_d;  rfault_q <= rfault_d;
    opv_q <= opv_d;  opc_q <= opc_d;  ohalt_q <= ohalt_d;  oval_q <= oval_d;
    ofault_q <= ofault_d;
  end

  assign in_ready_o      = (state_q == SIdle);
  assign out_valid_o     = ov_q;
  assign print_valid_o   = opv_q;
  assign print_as_char_o = opc_q;
  assign print_value_o   = oval_q;
  assign halted_o        = ohalt_q;
  assign fault_o         = ofault_q;

  // checks
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("second beat taken");
  a_irq_kernel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_q != acpu_pkg::IrqNone |-> kern_q) else $error("interrupt in user mode");
  a_mem_fault_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fault_o == acpu_pkg::FaultMem |-> halted_o)
    else $error("violation without halt");
  a_print_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && print_valid_o |-> !halted_o && fault_o == acpu_pkg::FaultNone)
    else $error("print with halt or fault");

endmodule

// File: tb/sv/tb_accumulator_cpu_with_interrupts_core.sv
// tb_accumulator_cpu_with_interrupts_core: self-checking bench for the accumulator processor
// drives load and step beats, predicts every result beat and compares it field by field
// depends on acpu_pkg and accumulator_cpu_with_interrupts_core
`timescale 1ns / 1ps

module tb_accumulator_cpu_with_interrupts_core;
  import acpu_pkg::*;

  // item kinds and port numbers
  localparam logic KindLoad = 1'b0;
  localparam logic KindStep = 1'b1;
  localparam logic [31:0] PortInt  = 32'd1;
  localparam logic [31:0] PortChar = 32'd2;

  // opcodes
  localparam logic [31:0] OpLdVal = 32'd1,  OpLdAddr = 32'd2,  OpLdInd = 32'd3;
  localparam logic [31:0] OpLdIdxX = 32'd4, OpLdIdxY = 32'd5,  OpLdSpX = 32'd6;
  localparam logic [31:0] OpStore = 32'd7,  OpRand = 32'd8,    OpPut = 32'd9;
  localparam logic [31:0] OpAddX = 32'd10,  OpAddY = 32'd11,   OpSubX = 32'd12;
  localparam logic [31:0] OpSubY = 32'd13,  OpToX = 32'd14,    OpFromX = 32'd15;
  localparam logic [31:0] OpToY = 32'd16,   OpFromY = 32'd17,  OpToSp = 32'd18;
  localparam logic [31:0] OpFromSp = 32'd19, OpJump = 32'd20,  OpJumpZ = 32'd21;
  localparam logic [31:0] OpJumpNz = 32'd22, OpCall = 32'd23,  OpRet = 32'd24;
  localparam logic [31:0] OpIncX = 32'd25,  OpDecX = 32'd26,   OpPush = 32'd27;
  localparam logic [31:0] OpPop = 32'd28,   OpSyscall = 32'd29, OpIret = 32'd30;
  localparam logic [31:0] OpEnd = 32'd50,   OpLastValid = 32'd30;

  // user pc beyond this is steered away so the machine keeps running
  localparam logic [AddrW-1:0] PcGuard = AddrW'(990);
  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned RandItems = 1850;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic        pv;
    logic        pch;
    logic [31:0] val;
    logic        halted;
    fault_e      fault;
  } res_t;

  typedef struct packed {
    logic             kind;
    logic [AddrW-1:0] addr;
    logic [31:0]      value;
    logic             typed;
    res_t             res;
  } row_t;

  logic        clk_i, rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_data_i;
  logic        in_valid_i, in_ready_o;
  logic        kind_i;
  logic [10:0] load_address_i;
  logic signed [31:0] load_value_i;
  logic        out_valid_o, out_ready_i;
  logic        print_valid_o, print_as_char_o;
  logic signed [31:0] print_value_o;
  logic        halted_o;
  logic [1:0]  fault_o;

  accumulator_cpu_with_interrupts_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .load_address_i (load_address_i),
    .load_value_i   (load_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .print_valid_o  (print_valid_o),
    .print_as_char_o(print_as_char_o),
    .print_value_o  (print_value_o),
    .halted_o       (halted_o),
    .fault_o        (fault_o)
  );

  // machine state mirror
  word_t            cpu_mem [MemDepth];
  logic [AddrW-1:0] cpu_pc, cpu_sp;
  word_t            cpu_ac, cpu_x, cpu_y;
  logic             cpu_kernel, cpu_tpend, cpu_stopped;
  irq_e             cpu_irq;
  logic [15:0]      cpu_tick, cpu_lfsr, timer_interval;

  // snapshot for trial steps
  word_t            snap_mem [MemDepth];
  logic [AddrW-1:0] snap_pc, snap_sp;
  word_t            snap_ac, snap_x, snap_y;
  logic             snap_kernel, snap_tpend, snap_stopped;
  irq_e             snap_irq;
  logic [15:0]      snap_tick, snap_lfsr;

  res_t pending_results[$];
  int   mismatches = 0;
  int   idle_cycles = 0;
  int   n_loads = 0, n_steps = 0, n_prints = 0, n_faults = 0, n_timer = 0;
  logic idle_on = 1'b1;

  // directed stimulus: program at 1..9, syscall handler at 1500
  row_t boot_rows [19] = '{
    '{KindStep, 11'd0,    32'd0,        1'b1, '{1'b0, 1'b0, 32'd0, 1'b0, FaultOpcode}},
    '{KindLoad, 11'd2047, 32'h7fffffff, 1'b1, '{1'b0, 1'b0, 32'd0, 1'b0, FaultNone}},
    '{KindLoad, 11'd1,    OpLdVal,      1'b1, '{1'b0, 1'b0, 32'd0, 1'b0, FaultNone}},
    '{KindLoad, 11'd2,    32'h80000000, 1'b1, '{1'b0, 1'b0, 32'd0, 1'b0, FaultNone}},
    '{KindLoad, 11'd3,    OpPut,        1'b1, '{1'b0, 1'b0, 32'd0, 1'b0, FaultNone}},
    '{KindLoad, 11'd4,    PortInt,      1'b1, '{1'b0, 1'b0, 32'd0, 1'b0, FaultNone}},
    '{KindLoad, 11'd5,    OpPut,        1'b1, '{1'b0, 1'b0, 32'd0, 1'b0, FaultNone}},
    '{KindLoad, 11'd6,    PortChar,     1'b1, '{1'b0, 1'b0, 32'd0, 1'b0, FaultNone}},
    '{KindLoad, 11'd7,    OpSyscall,    1'b1, '{1'b0, 1'b0, 32'd0, 1'b0, FaultNone}},
    '{KindLoad, 11'd1500, OpIret,       1'b1, '{1'b0, 1'b0, 32'd0, 1'b0, FaultNone}},
    '{KindLoad, 11'd8,    OpRand,       1'b1, '{1'b0, 1'b0, 32'd0, 1'b0, FaultNone}},
    '{KindLoad, 11'd9,    32'hffffffff, 1'b1, '{1'b0, 1'b0, 32'd0, 1'b0, FaultNone}},
    '{KindStep, 11'd0,    32'd0,        1'b1, '{1'b0, 1'b0, 32'd0, 1'b0, FaultNone}},
    '{KindStep, 11'd0,    32'd0,        1'b1, '{1'b1, 1'b0, 32'h80000000, 1'b0, FaultNone}},
    '{KindStep, 11'd0,    32'd0,        1'b1, '{1'b1, 1'b1, 32'h80000000, 1'b0, FaultNone}},
    '{KindStep, 11'd0,    32'd0,        1'b0, '{1'b0, 1'b0, 32'd0, 1'b0, FaultNone}},
    '{KindStep, 11'd0,    32'd0,        1'b0, '{1'b0, 1'b0, 32'd0, 1'b0, FaultNone}},
    '{KindStep, 11'd0,    32'd0,        1'b0, '{1'b0, 1'b0, 32'd0, 1'b0, FaultNone}},
    '{KindStep, 11'd0,    32'd0,        1'b1, '{1'b0, 1'b0, 32'd0, 1'b0, FaultOpcode}}
  };

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic may_touch(input logic [AddrW-1:0] a);
    return cpu_kernel || (a < UserLimit);
  endfunction

  function automatic logic [AddrW-1:0] fetch_addr();
    return (cpu_tpend && cpu_irq == IrqNone) ? TimerEntry : cpu_pc;
  endfunction

  task automatic enter_irq(input logic [AddrW-1:0] resume, input irq_e why);
    cpu_irq            = why;
    cpu_kernel         = 1'b1;
    cpu_mem[StackHi]   = word_t'(resume);
    cpu_mem[StackLo]   = word_t'(cpu_sp);
    cpu_sp             = StackLo;
  endtask

  // predict the result of one beat and advance the mirrored machine
  task automatic cpu_execute(input logic kind, input logic [AddrW-1:0] la,
                             input word_t lv, output res_t r);
    word_t            op, opnd;
    logic [AddrW-1:0] npc, a, b;
    logic             two, viol;
    r = '0;
    viol = 1'b0;
    opnd = '0;
    op = '0;
    npc = cpu_pc;
    if (kind == KindLoad) begin
      cpu_mem[la] = lv;
      r.halted = cpu_stopped;
      return;
    end
    if (cpu_stopped) begin
      r.halted = 1'b1;
      return;
    end
    // timer entry ahead of fetch
    if (cpu_tpend && cpu_irq == IrqNone) begin
      cpu_tpend = 1'b0;
      enter_irq(cpu_pc, IrqTimer);
      cpu_pc = TimerEntry;
    end
    // fetch and operand
    if (!may_touch(cpu_pc)) viol = 1'b1;
    else begin
      op = cpu_mem[cpu_pc];
      two = (op >= OpLdVal && op <= OpLdIdxY) || op == OpStore || op == OpPut ||
            (op >= OpJump && op <= OpCall);
      if (two) begin
        a = cpu_pc + 1'b1;
        if (!may_touch(a)) viol = 1'b1;
        else opnd = cpu_mem[a];
      end
      npc = cpu_pc + (two ? AddrW'(2) : AddrW'(1));
    end
    // execute
    if (!viol) begin
      case (op)
        OpLdVal:  cpu_ac = opnd;
        OpLdAddr: begin
          a = opnd[AddrW-1:0];
          if (!may_touch(a)) viol = 1'b1; else cpu_ac = cpu_mem[a];
        end
        OpLdInd: begin
          a = opnd[AddrW-1:0];
          if (!may_touch(a)) viol = 1'b1;
          else begin
            a = cpu_mem[a][AddrW-1:0];
            if (!may_touch(a)) viol = 1'b1; else cpu_ac = cpu_mem[a];
          end
        end
        OpLdIdxX, OpLdIdxY: begin
          a = AddrW'(opnd + ((op == OpLdIdxX) ? cpu_x : cpu_y));
          if (!may_touch(a)) viol = 1'b1; else cpu_ac = cpu_mem[a];
        end
        OpLdSpX: begin
          a = AddrW'(word_t'(cpu_sp) + cpu_x);
          if (!may_touch(a)) viol = 1'b1; else cpu_ac = cpu_mem[a];
        end
        OpStore: begin
          a = opnd[AddrW-1:0];
          if (!may_touch(a)) viol = 1'b1; else cpu_mem[a] = cpu_ac;
        end
        OpRand: begin
          cpu_lfsr = cpu_lfsr[0] ? ((cpu_lfsr >> 1) ^ LfsrTaps) : (cpu_lfsr >> 1);
          cpu_ac = word_t'(cpu_lfsr) % RndRange + 32'd1;
        end
        OpPut: begin
          if (opnd == PortInt || opnd == PortChar) begin
            r.pv  = 1'b1;
            r.pch = (opnd == PortChar);
            r.val = cpu_ac;
          end
        end
        OpAddX:   cpu_ac = cpu_ac + cpu_x;
        OpAddY:   cpu_ac = cpu_ac + cpu_y;
        OpSubX:   cpu_ac = cpu_ac - cpu_x;
        OpSubY:   cpu_ac = cpu_ac - cpu_y;
        OpToX:    cpu_x = cpu_ac;
        OpFromX:  cpu_ac = cpu_x;
        OpToY:    cpu_y = cpu_ac;
        OpFromY:  cpu_ac = cpu_y;
        OpToSp:   cpu_sp = cpu_ac[AddrW-1:0];
        OpFromSp: cpu_ac = word_t'(cpu_sp);
        OpJump:   npc = opnd[AddrW-1:0];
        OpJumpZ:  if (cpu_ac == 0) npc = opnd[AddrW-1:0];
        OpJumpNz: if (cpu_ac != 0) npc = opnd[AddrW-1:0];
        OpCall: begin
          a = cpu_sp - 1'b1;
          if (!may_touch(a)) viol = 1'b1;
          else begin
            cpu_mem[a] = word_t'(npc);
            cpu_sp = a;
            npc = opnd[AddrW-1:0];
          end
        end
        OpRet: begin
          if (!may_touch(cpu_sp)) viol = 1'b1;
          else begin
            npc = cpu_mem[cpu_sp][AddrW-1:0];
            cpu_sp = cpu_sp + 1'b1;
          end
        end
        OpIncX:   cpu_x = cpu_x + 1;
        OpDecX:   cpu_x = cpu_x - 1;
        OpPush: begin
          a = cpu_sp - 1'b1;
          if (!may_touch(a)) viol = 1'b1;
          else begin
            cpu_mem[a] = cpu_ac;
            cpu_sp = a;
          end
        end
        OpPop: begin
          if (!may_touch(cpu_sp)) viol = 1'b1;
          else begin
            cpu_ac = cpu_mem[cpu_sp];
            cpu_sp = cpu_sp + 1'b1;
          end
        end
        OpSyscall: begin
          if (cpu_irq == IrqNone) begin
            enter_irq(npc, IrqSyscall);
            npc = SyscallEntry;
          end
        end
        OpIret: begin
          a = cpu_sp;
          b = cpu_sp + 1'b1;
          if (!may_touch(a) || !may_touch(b)) viol = 1'b1;
          else begin
            npc = cpu_mem[b][AddrW-1:0];
            if (cpu_irq == IrqTimer) cpu_tpend = 1'b0;
            cpu_irq = IrqNone;
            cpu_kernel = 1'b0;
            cpu_sp = cpu_mem[a][AddrW-1:0];
          end
        end
        OpEnd: begin
          cpu_stopped = 1'b1;
          r.halted = 1'b1;
          return;
        end
        default: r.fault = FaultOpcode;
      endcase
    end
    // violation halts with no further effect
    if (viol) begin
      cpu_stopped = 1'b1;
      r = '0;
      r.halted = 1'b1;
      r.fault = FaultMem;
      return;
    end
    // commit and count the tick
    cpu_pc = npc;
    cpu_tick = cpu_tick + 1'b1;
    if (timer_interval != 0 && cpu_tick >= timer_interval) begin
      cpu_tpend = 1'b1;
      cpu_tick = '0;
    end
  endtask

  task automatic save_cpu();
    snap_mem = cpu_mem; snap_pc = cpu_pc; snap_sp = cpu_sp; snap_ac = cpu_ac;
    snap_x = cpu_x; snap_y = cpu_y; snap_kernel = cpu_kernel; snap_tpend = cpu_tpend;
    snap_stopped = cpu_stopped; snap_irq = cpu_irq; snap_tick = cpu_tick;
    snap_lfsr = cpu_lfsr;
  endtask

  task automatic restore_cpu();
    cpu_mem = snap_mem; cpu_pc = snap_pc; cpu_sp = snap_sp; cpu_ac = snap_ac;
    cpu_x = snap_x; cpu_y = snap_y; cpu_kernel = snap_kernel; cpu_tpend = snap_tpend;
    cpu_stopped = snap_stopped; cpu_irq = snap_irq; cpu_tick = snap_tick;
    cpu_lfsr = snap_lfsr;
  endtask

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // instruction-like word: mostly valid opcodes, some halts, invalid codes and operands
  function automatic word_t code_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 62) return word_t'($urandom_range(1, 30));
    if (r < 65) return OpEnd;
    if (r < 69) return (r == 68) ? word_t'(0) : word_t'($urandom_range(31, 49));
    if (r < 75) return word_t'($urandom_range(1, 2));
    if (r < 97) return word_t'($urandom_range(0, 999));
    return $urandom();
  endfunction

  // present one beat and hold it until accepted; expected result queued at drive time
  task automatic send_beat(input logic kind, input logic [AddrW-1:0] la, input word_t lv,
                           input logic typed, input res_t typed_res);
    int   gap;
    res_t r;
    gap = gap_len();
    if (gap > 0) begin
      @(negedge clk_i) in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    cpu_execute(kind, la, lv, r);
    if (typed) r = typed_res;
    pending_results.push_back(r);
    if (kind == KindLoad) n_loads++; else n_steps++;
    if (r.pv) n_prints++;
    if (r.fault != FaultNone) n_faults++;
    in_valid_i     = 1'b1;
    kind_i         = kind;
    load_address_i = la;
    load_value_i   = lv;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic load_word(input logic [AddrW-1:0] la, input word_t lv);
    send_beat(KindLoad, la, lv, 1'b0, '0);
  endtask

  // run a step unless it would stop the machine or push user pc out of range
  task automatic guarded_step();
    res_t             r;
    logic             bad;
    logic [AddrW-1:0] fa;
    fa = fetch_addr();
    save_cpu();
    cpu_execute(KindStep, '0, '0, r);
    bad = r.halted || (!cpu_kernel && cpu_pc >= PcGuard);
    restore_cpu();
    if (bad) begin
      load_word(fa, OpJump);
      load_word(fa + 1'b1, word_t'($urandom_range(0, 899)));
    end else begin
      if (cpu_tpend && cpu_irq == IrqNone) n_timer++;
      send_beat(KindStep, '0, '0, 1'b0, '0);
    end
  endtask

  // one random item: program words near the fetch point, handler words, noise, or a step
  task automatic random_item(input logic guarded);
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) load_word(fetch_addr() + AddrW'($urandom_range(0, 5)), code_word());
    else if (r < 29) load_word(($urandom_range(0, 1) ? TimerEntry : SyscallEntry) +
                               AddrW'($urandom_range(0, 3)),
                               ($urandom_range(0, 2) == 0) ? OpIret : code_word());
    else if (r < 33) load_word(AddrW'($urandom_range(0, MemDepth - 1)), $urandom());
    else if (guarded) guarded_step();
    else send_beat(KindStep, '0, '0, 1'b0, '0);
  endtask

  task automatic drain_and_pause();
    @(negedge clk_i) in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_interval(input logic [15:0] v);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_data_i = v;
    timer_interval = v;
    @(negedge clk_i) cfg_we_i = 1'b0;
  endtask

  // stimulus
  initial begin
    logic [15:0] settings [6];
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    kind_i = KindLoad;
    load_address_i = '0;
    load_value_i = '0;
    foreach (cpu_mem[i]) cpu_mem[i] = '0;
    cpu_pc = '0; cpu_sp = UserLimit; cpu_ac = '0; cpu_x = '0; cpu_y = '0;
    cpu_kernel = 1'b0; cpu_tpend = 1'b0; cpu_stopped = 1'b0; cpu_irq = IrqNone;
    cpu_tick = '0; cpu_lfsr = LfsrSeed; timer_interval = '0;
    settings = '{16'd1, 16'd65535, 16'd7, 16'd23, 16'd3, 16'd0};
    settings[5] = 16'($urandom_range(2, 60));
    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    write_interval(16'd0);

    // directed rows
    foreach (boot_rows[i])
      send_beat(boot_rows[i].kind, boot_rows[i].addr, boot_rows[i].value,
                boot_rows[i].typed, boot_rows[i].res);

    // random phases, one timer setting each; one phase runs without gaps
    for (int p = 0; p < 6; p++) begin
      drain_and_pause();
      write_interval(settings[p]);
      idle_on = (p != 2);
      for (int n = 0; n < RandItems / 6; n++) random_item(1'b1);
    end

    // let the machine run free until it stops, then check the halted behavior
    drain_and_pause();
    idle_on = 1'b1;
    for (int n = 0; n < 60 && !cpu_stopped; n++) random_item(1'b0);
    if (!cpu_stopped) begin
      load_word(fetch_addr(), OpEnd);
      send_beat(KindStep, '0, '0, 1'b0, '0);
    end
    send_beat(KindStep, '0, '0, 1'b1, '{1'b0, 1'b0, 32'd0, 1'b1, FaultNone});
    send_beat(KindLoad, 11'd5, 32'h5a5a5a5a, 1'b1, '{1'b0, 1'b0, 32'd0, 1'b1, FaultNone});
    send_beat(KindStep, '0, '0, 1'b1, '{1'b0, 1'b0, 32'd0, 1'b1, FaultNone});

    drain_and_pause();
    $display("covered %0d loads and %0d steps, %0d prints, %0d faults, %0d timer entries",
             n_loads, n_steps, n_prints, n_faults, n_timer);
    $display("timer settings 0, 1, 65535 and random; %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // result side ready with random stalls
  initial begin
    int n;
    out_ready_i = 1'b0;
    forever begin
      n = gap_len();
      if (n > 0) begin
        @(negedge clk_i) out_ready_i = 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end
      @(negedge clk_i) out_ready_i = 1'b1;
      repeat ($urandom_range(0, 8)) @(negedge clk_i);
    end
  end

  // compare each result beat with the oldest prediction; watchdog on idle cycles
  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
      end else begin
        e = pending_results.pop_front();
        if (print_valid_o !== e.pv || print_as_char_o !== e.pch ||
            print_value_o !== e.val || halted_o !== e.halted || fault_o !== e.fault) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: exp pv %0b ch %0b val %h halt %0b fault %0d, got %0b %0b %h %0b %0d",
                     $realtime, e.pv, e.pch, e.val, e.halted, e.fault,
                     print_valid_o, print_as_char_o, print_value_o, halted_o, fault_o);
        end
      end
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog expired with %0d results pending", pending_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule
